[hdl/mhsa_pkg.sv]
// ----------------------------------------------------------------------------
// mhsa_pkg
// Shared types, constants and helpers for the masked Hamming-sum argmin block.
// ----------------------------------------------------------------------------
package mhsa_pkg;

   // field widths
   localparam int SIG_W   = 32;
   localparam int LABEL_W = 8;
   localparam int SCORE_W = 12;
   localparam int ONES_W  = $clog2(SIG_W + 1);

   // significant signature bits; words are always SIG_W wide on the ports
   localparam int SIG_BITS = 32;
   localparam logic [SIG_W-1:0] SIG_MASK =
      (SIG_BITS >= SIG_W) ? {SIG_W{1'b1}} : SIG_W'((64'd1 << SIG_BITS) - 64'd1);

   localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

   // queue depth between front and back, and of the result queue
   localparam int QUEUE_DEPTH = 4;

   // request function codes
   localparam logic FUNC_TABLE  = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   typedef struct packed {
      logic               func;
      logic [SIG_W-1:0]   query_sig;
      logic [SIG_W-1:0]   cand_sig;
      logic [LABEL_W-1:0] cand_label;
      logic               table_last;
   } req_type;

   typedef struct packed {
      logic [LABEL_W-1:0] win_label;
      logic               found;
   } rsp_type;

   // classified operation handed from front to back
   typedef struct packed {
      logic               func;
      logic [ONES_W-1:0]  ones;
      logic [LABEL_W-1:0] label;
      logic               last;
   } op_type;

   // number of set bits in a signature word
   function automatic logic [ONES_W-1:0] count_ones(input logic [SIG_W-1:0] v);
      logic [ONES_W-1:0] n;
      n = '0;
      for (int i = 0; i < SIG_W; i++) begin
         n = n + ONES_W'(v[i]);
      end
      return n;
   endfunction

endpackage

[hdl/mhsa_fifo.sv]
// ----------------------------------------------------------------------------
// mhsa_fifo
// Small register-based first-in first-out queue with full and empty flags.
// ----------------------------------------------------------------------------
module mhsa_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[hdl/mhsa_front.sv]
// ----------------------------------------------------------------------------
// mhsa_front
// Accepts requests, masks the signature difference and counts its ones.
// ----------------------------------------------------------------------------
module mhsa_front
   import mhsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_type          req_data,
   output logic             req_full,
   input  logic [SIG_W-1:0] bit_mask,
   output logic             op_push,
   output op_type           op_data,
   input  logic             op_full
);

   logic               valid_ff, valid_in;
   logic               func_ff, func_in;
   logic [SIG_W-1:0]   diff_ff, diff_in;
   logic [LABEL_W-1:0] label_ff, label_in;
   logic               last_ff, last_in;
   logic               accept;

   // stage holds while the queue is full
   assign req_full = valid_ff && op_full;
   assign accept   = req_push && !req_full;
   assign op_push  = valid_ff && !op_full;

   always_comb begin
      valid_in = accept || req_full;
      func_in  = func_ff;
      diff_in  = diff_ff;
      label_in = label_ff;
      last_in  = last_ff;
      if (accept) begin
         func_in  = req_data.func;
         diff_in  = (req_data.query_sig ^ req_data.cand_sig) & bit_mask & SIG_MASK;
         label_in = req_data.cand_label;
         last_in  = req_data.table_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff  <= func_in;
      diff_ff  <= diff_in;
      label_ff <= label_in;
      last_ff  <= last_in;
   end

   // classified op toward the back end
   always_comb begin
      op_data.func  = func_ff;
      op_data.ones  = count_ones(diff_ff);
      op_data.label = label_ff;
      op_data.last  = last_ff;
   end

endmodule

[hdl/mhsa_back.sv]
// ----------------------------------------------------------------------------
// mhsa_back
// Accumulates candidate scores, tracks the best one and queues finish results.
// ----------------------------------------------------------------------------
module mhsa_back
   import mhsa_pkg::*;
#(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic    clock,
   input  logic    reset,
   input  op_type  op_data,
   input  logic    op_empty,
   output logic    op_pop,
   output logic    rsp_empty,
   input  logic    rsp_pop,
   output rsp_type rsp_data
);

   localparam int RSP_W = $bits(rsp_type);

   logic [SCORE_W-1:0] running_ff, running_in;
   logic [SCORE_W-1:0] low_score_ff, low_score_in;
   logic [LABEL_W-1:0] best_class_ff, best_class_in;
   logic               any_found_ff, any_found_in;
   logic [SCORE_W:0]   sum;
   logic [SCORE_W-1:0] score;
   logic               res_push, res_full;
   rsp_type            res_data;
   logic [RSP_W-1:0]   res_rd;

   // a finish op waits for room in the result queue
   assign op_pop = !op_empty && ((op_data.func == FUNC_TABLE) || !res_full);

   // saturating score for the current table
   assign sum   = {1'b0, running_ff} + (SCORE_W + 1)'(op_data.ones);
   assign score = sum[SCORE_W] ? SCORE_MAX : sum[SCORE_W-1:0];

   always_comb begin
      running_in    = running_ff;
      low_score_in  = low_score_ff;
      best_class_in = best_class_ff;
      any_found_in  = any_found_ff;
      res_push      = 1'b0;
      res_data.win_label = any_found_ff ? best_class_ff : '0;
      res_data.found     = any_found_ff;
      if (op_pop) begin
         unique case (op_data.func)
            FUNC_FINISH: begin
               res_push      = 1'b1;
               running_in    = '0;
               low_score_in  = SCORE_MAX;
               best_class_in = '0;
               any_found_in  = 1'b0;
            end
            default: begin
               running_in = score;
               if (op_data.last) begin
                  // first closed candidate always wins; ties keep the earlier one
                  if (!any_found_ff || (score < low_score_ff)) begin
                     low_score_in  = score;
                     best_class_in = op_data.label;
                  end
                  any_found_in = 1'b1;
                  running_in   = '0;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         running_ff    <= '0;
         low_score_ff  <= SCORE_MAX;
         best_class_ff <= '0;
         any_found_ff  <= 1'b0;
      end else begin
         running_ff    <= running_in;
         low_score_ff  <= low_score_in;
         best_class_ff <= best_class_in;
         any_found_ff  <= any_found_in;
      end
   end

   // result queue
   mhsa_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (rsp_pop),
      .pop_data  (res_rd),
      .empty     (rsp_empty)
   );

   assign rsp_data = rsp_type'(res_rd);

endmodule

[hdl/masked_hamming_sum_argmin.sv]
// ----------------------------------------------------------------------------
// masked_hamming_sum_argmin
// Nearest-neighbor search by masked Hamming distance over streamed candidates.
// ----------------------------------------------------------------------------
// The block takes one request per clock while req_full is low. A table request
// carries one query and one candidate signature word; their masked difference
// is popcounted and added to the candidate's running score (saturating at
// 4095), and a request with table_last set closes the candidate. The lowest
// closed score wins, the earlier candidate on a tie. A finish request produces
// one response with the winning label and a found flag (label 0, found 0 when
// no candidate closed) and clears the search state; csr_wdata (bit_mask) is
// kept. Table requests produce no response. Throughput is one request per
// cycle while req_full is low, set by the front register stage (xor, mask,
// popcount) and the back stage's add and compare; the queue between them and
// the response queue absorb stalls on rsp_pop.
// Write csr_wdata only while no request is in flight.
module masked_hamming_sum_argmin
   import mhsa_pkg::*;
#(
   parameter int QUEUE_DEPTH_P = QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  req_type          req_data,
   output logic             req_full,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output rsp_type          rsp_data,
   input  logic             csr_we,
   input  logic [SIG_W-1:0] csr_wdata
);

   localparam int OP_W = $bits(op_type);

   logic [SIG_W-1:0] bit_mask_ff, bit_mask_in;
   logic             op_push, op_full, op_empty, op_pop;
   op_type           op_wr;
   logic [OP_W-1:0]  op_rd;

   // mask register
   assign bit_mask_in = csr_we ? csr_wdata : bit_mask_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         bit_mask_ff <= '1;
      end else begin
         bit_mask_ff <= bit_mask_in;
      end
   end

   mhsa_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .bit_mask (bit_mask_ff),
      .op_push  (op_push),
      .op_data  (op_wr),
      .op_full  (op_full)
   );

   // decoupling queue between front and back
   mhsa_fifo #(
      .WIDTH (OP_W),
      .DEPTH (QUEUE_DEPTH_P)
   ) u_op_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (op_push),
      .push_data (op_wr),
      .full      (op_full),
      .pop       (op_pop),
      .pop_data  (op_rd),
      .empty     (op_empty)
   );

   mhsa_back #(
      .DEPTH (QUEUE_DEPTH_P)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .op_data   (op_type'(op_rd)),
      .op_empty  (op_empty),
      .op_pop    (op_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule
